[hw/rtl/mck_pkg.sv]
// Shared types, constants and the Morse table for the keyer.
`default_nettype none
package mck_pkg;

    localparam int CHAR_W = 8;
    localparam int DIT_W  = 16;
    localparam int DUR_W  = 18;
    localparam int IDX_W  = 3;

    localparam logic [DIT_W-1:0] DIT_RESET = 16'd100;
    localparam logic [IDX_W-1:0] MAX_LEN   = 3'd5;
    localparam logic [IDX_W-1:0] TOP_BIT   = 3'd4;

    localparam logic [7:0] LETTER_CODES [26] = '{
        8'h50, 8'h8E, 8'h8A, 8'h6C, 8'h30, 8'h9A, 8'h64, 8'h9E, 8'h58, 8'h90,
        8'h68, 8'h96, 8'h40, 8'h48, 8'h60, 8'h92, 8'h84, 8'h74, 8'h7C, 8'h20,
        8'h78, 8'h9C, 8'h70, 8'h8C, 8'h88, 8'h86
    };

    localparam logic [7:0] DIGIT_CODES [10] = '{
        8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE, 8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ON,
        ST_OFF,
        ST_GAP,
        ST_EOM
    } mck_state_t;

    typedef enum logic [1:0] {
        SEG_ELEM,
        SEG_SPACE,
        SEG_GAP
    } mck_seg_t;

    typedef struct packed {
        logic     load;
        logic     emit;
        mck_seg_t seg;
        logic     last;
        logic     step;
    } mck_cmd_t;

    typedef struct packed {
        logic out_free;
        logic len_zero;
        logic elem_last;
        logic eom;
    } mck_status_t;

    // Packed entry: length in [7:5], elements from bit 4 down (1 = dit).
    function automatic logic [7:0] code_lookup(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] off;
        logic [7:0]        code;
        code = 8'h00;
        off  = 8'h00;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            off  = ch - 8'h41;
            code = LETTER_CODES[off[4:0]];
        end
        else if (ch >= 8'h30 && ch <= 8'h39) begin
            off  = ch - 8'h30;
            code = DIGIT_CODES[off[3:0]];
        end
        return code;
    endfunction

endpackage : mck_pkg
`default_nettype wire

[hw/rtl/mck_if.sv]
// Valid/ready channel interfaces for characters, key segments and configuration.
`default_nettype none
interface mck_char_if;
    import mck_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              end_of_message;

    modport source (output valid, output character, output end_of_message, input ready);
    modport sink   (input valid, input character, input end_of_message, output ready);
endinterface : mck_char_if

interface mck_seg_if;
    import mck_pkg::*;

    logic             valid;
    logic             ready;
    logic             key_on;
    logic [DUR_W-1:0] duration_ms;
    logic             last;

    modport source (output valid, output key_on, output duration_ms, output last, input ready);
    modport sink   (input valid, input key_on, input duration_ms, input last, output ready);
endinterface : mck_seg_if

interface mck_cfg_if;
    import mck_pkg::*;

    logic             valid;
    logic             ready;
    logic [DIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : mck_cfg_if
`default_nettype wire

[hw/rtl/mck_ctrl.sv]
// Keyer sequencer: walks the elements of one character, then the gaps.
`default_nettype none
module mck_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 chr_valid,
    output logic                      chr_ready,
    input  wire mck_pkg::mck_status_t status,
    output mck_pkg::mck_cmd_t         cmd
);
    import mck_pkg::*;

    mck_state_t state_reg;
    mck_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (chr_valid)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = status.len_zero ? ST_GAP : ST_ON;
            end
            ST_ON:
            begin
                if (status.out_free)
                    state_next = ST_OFF;
            end
            ST_OFF:
            begin
                if (status.out_free)
                    state_next = status.elem_last ? ST_GAP : ST_ON;
            end
            ST_GAP:
            begin
                if (status.out_free)
                    state_next = status.eom ? ST_EOM : ST_IDLE;
            end
            ST_EOM:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        chr_ready = 1'b0;
        cmd       = '{load: 1'b0, emit: 1'b0, seg: SEG_GAP, last: 1'b0, step: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                chr_ready = 1'b1;
                cmd.load  = chr_valid;
            end
            ST_LOAD:
            begin
            end
            ST_ON:
            begin
                cmd.emit = status.out_free;
                cmd.seg  = SEG_ELEM;
            end
            ST_OFF:
            begin
                cmd.emit = status.out_free;
                cmd.seg  = SEG_SPACE;
                cmd.step = status.out_free;
            end
            ST_GAP:
            begin
                cmd.emit = status.out_free;
                cmd.seg  = SEG_GAP;
                cmd.last = !status.eom;
            end
            ST_EOM:
            begin
                cmd.emit = status.out_free;
                cmd.seg  = SEG_GAP;
                cmd.last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule : mck_ctrl
`default_nettype wire

[hw/rtl/mck_dp.sv]
// Keyer datapath: character code, element index, dit/dah times, output register.
`default_nettype none
module mck_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [mck_pkg::CHAR_W-1:0]  character,
    input  wire logic                        end_of_message,
    input  wire logic                        cfg_we,
    input  wire logic [mck_pkg::DIT_W-1:0]   cfg_data,
    input  wire mck_pkg::mck_cmd_t           cmd,
    output mck_pkg::mck_status_t             status,
    mck_seg_if.source                        seg
);
    import mck_pkg::*;

    logic [7:0]       code_reg;
    logic [IDX_W-1:0] len_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             eom_reg;
    logic [DIT_W-1:0] dit_reg;
    logic [DUR_W-1:0] dah_reg;
    logic             out_valid_reg;
    logic             out_key_reg;
    logic [DUR_W-1:0] out_dur_reg;
    logic             out_last_reg;

    logic [7:0]       code_next;
    logic [IDX_W-1:0] len_next;
    logic [DUR_W-1:0] dit_ext;
    logic [DUR_W-1:0] dah_next;
    logic             elem_dit;
    logic             out_key_next;
    logic [DUR_W-1:0] out_dur_next;

    assign code_next = code_lookup(character);
    assign len_next  = (code_next[7:5] > MAX_LEN) ? MAX_LEN : code_next[7:5];
    assign dah_next  = {2'b00, cfg_data} + {1'b0, cfg_data, 1'b0};
    assign dit_ext   = {2'b00, dit_reg};
    assign elem_dit  = code_reg[TOP_BIT - idx_reg];

    assign status.out_free  = !out_valid_reg || seg.ready;
    assign status.len_zero  = (len_reg == '0);
    assign status.elem_last = (idx_reg == len_reg - 3'd1);
    assign status.eom       = eom_reg;

    always_comb
    begin
        out_key_next = 1'b0;
        out_dur_next = dah_reg;
        case (cmd.seg)
            SEG_ELEM:
            begin
                out_key_next = 1'b1;
                out_dur_next = elem_dit ? dit_ext : dah_reg;
            end
            SEG_SPACE:
            begin
                out_dur_next = dit_ext;
            end
            SEG_GAP:
            begin
                out_dur_next = dah_reg;
            end
            default:
            begin
                out_dur_next = dah_reg;
            end
        endcase
    end

    // dah time kept precomputed; only changes on a config transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dit_reg <= DIT_RESET;
            dah_reg <= {2'b00, DIT_RESET} + {1'b0, DIT_RESET, 1'b0};
        end
        else if (cfg_we)
        begin
            dit_reg <= cfg_data;
            dah_reg <= dah_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.step)
                idx_reg <= idx_reg + 3'd1;

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (seg.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg <= code_next;
            len_reg  <= len_next;
            eom_reg  <= end_of_message;
        end
        if (cmd.emit)
        begin
            out_key_reg  <= out_key_next;
            out_dur_reg  <= out_dur_next;
            out_last_reg <= cmd.last;
        end
    end

    assign seg.valid       = out_valid_reg;
    assign seg.key_on      = out_key_reg;
    assign seg.duration_ms = out_dur_reg;
    assign seg.last        = out_last_reg;

    a_load_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.emit)
        else $error("load and emit in the same cycle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || seg.ready))
        else $error("segment overwritten before transaction");

    a_last_is_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> !out_key_reg)
        else $error("final segment has key on");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (idx_reg < len_reg))
        else $error("element index past character length");

endmodule : mck_dp
`default_nettype wire

[hw/rtl/morse_code_keyer_top.sv]
// Morse keyer: one ASCII character in, timed key segments out.
// After the character transaction the sequencer passes ST_LOAD, then registers the first segment.
// Throughput: one segment per cycle while the output register is free (empty or seg.ready);
// the sequencer visits one segment per state step, with ST_IDLE and ST_LOAD between characters.
// Next character is taken while the final segment still waits in the output register.
// Reset: sequencer idle, output empty, dit time 100 ms.
`default_nettype none
module morse_code_keyer_top (
    input  wire logic clk,
    input  wire logic rst_n,
    mck_char_if.sink  chr,
    mck_seg_if.source seg,
    mck_cfg_if.sink   cfg
);
    import mck_pkg::*;

    mck_cmd_t    cmd;
    mck_status_t status;

    assign cfg.ready = 1'b1;

    mck_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .chr_valid (chr.valid),
        .chr_ready (chr.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mck_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .character      (chr.character),
        .end_of_message (chr.end_of_message),
        .cfg_we         (cfg.valid),
        .cfg_data       (cfg.data),
        .cmd            (cmd),
        .status         (status),
        .seg            (seg)
    );

endmodule : morse_code_keyer_top
`default_nettype wire

[verif/mck_checker.sv]
// Keyer checker: predicts key segments from accepted characters and compares them.
module mck_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       chr_valid,
    input  logic                       chr_ready,
    input  logic [mck_pkg::CHAR_W-1:0] chr_character,
    input  logic                       chr_end_of_message,
    input  logic                       seg_valid,
    input  logic                       seg_ready,
    input  logic                       seg_key_on,
    input  logic [mck_pkg::DUR_W-1:0]  seg_duration_ms,
    input  logic                       seg_last,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [mck_pkg::DIT_W-1:0]  cfg_data,
    output int                         err_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mck_pkg::*;

    localparam logic [DIT_W-1:0] DIT_AT_RESET = 16'd100;
    localparam int               MAX_ELEMS    = 5;

    // length in [7:5], elements from bit 4 down, 1 = dit
    localparam logic [7:0] ALPHA_MORSE [26] = '{
        8'h50, 8'h8E, 8'h8A, 8'h6C, 8'h30, 8'h9A, 8'h64, 8'h9E, 8'h58, 8'h90,
        8'h68, 8'h96, 8'h40, 8'h48, 8'h60, 8'h92, 8'h84, 8'h74, 8'h7C, 8'h20,
        8'h78, 8'h9C, 8'h70, 8'h8C, 8'h88, 8'h86
    };
    localparam logic [7:0] NUMERAL_MORSE [10] = '{
        8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE, 8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1
    };

    typedef struct packed {
        logic             key_on;
        logic [DUR_W-1:0] duration_ms;
        logic             last;
    } key_seg_t;

    key_seg_t         key_seg_q [$];
    logic [DIT_W-1:0] dit_ms;
    int               n_err;

    task automatic predict_segments(input logic [7:0] ch, input logic eom);
        logic [7:0]       code;
        int               n_elem;
        logic [DUR_W-1:0] dit_dur;
        logic [DUR_W-1:0] dah_dur;
        code = 8'h00;
        if (ch >= "A" && ch <= "Z")
        begin
            code = ALPHA_MORSE[ch - "A"];
        end
        else if (ch >= "0" && ch <= "9")
        begin
            code = NUMERAL_MORSE[ch - "0"];
        end
        n_elem = int'(code[7:5]);
        if (n_elem > MAX_ELEMS)
        begin
            n_elem = MAX_ELEMS;
        end
        dit_dur = {2'b00, dit_ms};
        dah_dur = dit_dur * 18'd3;
        for (int i = 0; i < n_elem; i++)
        begin
            key_seg_q.push_back('{1'b1, code[4-i] ? dit_dur : dah_dur, 1'b0});
            key_seg_q.push_back('{1'b0, dit_dur, 1'b0});
        end
        key_seg_q.push_back('{1'b0, dah_dur, !eom});
        if (eom)
        begin
            key_seg_q.push_back('{1'b0, dah_dur, 1'b1});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        key_seg_t want;
        if (!rst_n)
        begin
            key_seg_q.delete();
            dit_ms    = DIT_AT_RESET;
            n_err     = 0;
            err_count <= 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                dit_ms = cfg_data;
            end
            if (seg_valid && seg_ready)
            begin
                if (key_seg_q.size() == 0)
                begin
                    n_err++;
                    $display("%0t: unexpected segment: actual key_on=%0d duration_ms=%0d last=%0d",
                             $time, seg_key_on, seg_duration_ms, seg_last);
                end
                else
                begin
                    want = key_seg_q.pop_front();
                    if (want.key_on !== seg_key_on)
                    begin
                        n_err++;
                        $display("%0t: key_on mismatch: expected %0d actual %0d",
                                 $time, want.key_on, seg_key_on);
                    end
                    if (want.duration_ms !== seg_duration_ms)
                    begin
                        n_err++;
                        $display("%0t: duration_ms mismatch: expected %0d actual %0d",
                                 $time, want.duration_ms, seg_duration_ms);
                    end
                    if (want.last !== seg_last)
                    begin
                        n_err++;
                        $display("%0t: last mismatch: expected %0d actual %0d",
                                 $time, want.last, seg_last);
                    end
                end
            end
            if (chr_valid && chr_ready)
            begin
                predict_segments(chr_character, chr_end_of_message);
            end
            err_count <= n_err;
            pending   <= key_seg_q.size();
        end
    end

endmodule : mck_checker

[verif/tb_morse_code_keyer_top.sv]
// Testbench top for the Morse keyer: clock, reset, stimulus and verdict.
module tb_morse_code_keyer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mck_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 26;

    logic clk;
    logic rst_n;
    int   err_count;
    int   pending;
    bit   no_idle;
    bit   hold_req;

    mck_char_if chr_if ();
    mck_seg_if  seg_if ();
    mck_cfg_if  cfg_if ();

    morse_code_keyer_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .chr   (chr_if),
        .seg   (seg_if),
        .cfg   (cfg_if)
    );

    mck_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .chr_valid          (chr_if.valid),
        .chr_ready          (chr_if.ready),
        .chr_character      (chr_if.character),
        .chr_end_of_message (chr_if.end_of_message),
        .seg_valid          (seg_if.valid),
        .seg_ready          (seg_if.ready),
        .seg_key_on         (seg_if.key_on),
        .seg_duration_ms    (seg_if.duration_ms),
        .seg_last           (seg_if.last),
        .cfg_valid          (cfg_if.valid),
        .cfg_ready          (cfg_if.ready),
        .cfg_data           (cfg_if.data),
        .err_count          (err_count),
        .pending            (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // segment sink: random back-pressure, plus one long hold on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                seg_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                seg_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                seg_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic eom);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            chr_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        chr_if.valid          <= 1'b1;
        chr_if.character      <= ch;
        chr_if.end_of_message <= eom;
        do
            @(posedge clk);
        while (!chr_if.ready);
    endtask

    // stop sending and let every outstanding segment drain
    task automatic drain_segments();
        chr_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_dit(input logic [DIT_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0]       ch;
        logic [DIT_W-1:0] dit;
        no_idle               = 1'b0;
        hold_req              = 1'b0;
        rst_n                 <= 1'b0;
        chr_if.valid          <= 1'b0;
        chr_if.character      <= 8'h00;
        chr_if.end_of_message <= 1'b0;
        seg_if.ready          <= 1'b0;
        cfg_if.valid          <= 1'b0;
        cfg_if.data           <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset dit time: table edges, all-dit / all-dah digits, non-table codes
        send_char("A", 1'b0);
        send_char("Z", 1'b0);
        send_char("Q", 1'b1);
        send_char("E", 1'b0);
        send_char("T", 1'b0);
        send_char("0", 1'b0);
        send_char("5", 1'b0);
        send_char("9", 1'b1);
        send_char("@", 1'b0);
        send_char("[", 1'b0);
        send_char("/", 1'b0);
        send_char(":", 1'b1);
        send_char("a", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h80, 1'b1);
        send_char(8'hFF, 1'b0);
        drain_segments();

        write_dit(16'd1);
        send_char("H", 1'b0);
        send_char("0", 1'b1);
        send_char(" ", 1'b0);
        drain_segments();

        // zero dit time gives zero-length segments
        write_dit(16'd0);
        send_char("K", 1'b1);
        send_char("~", 1'b0);
        drain_segments();

        write_dit(16'hFFFF);
        send_char("0", 1'b1);
        send_char("5", 1'b0);
        send_char(8'h7F, 1'b1);
        drain_segments();

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: dit = 16'($urandom_range(1, 65535));
                1: dit = 16'hFFFF;
                2: dit = 16'd1;
                3: dit = 16'($urandom);
                4: dit = 16'($urandom_range(2, 20));
                default: dit = 16'($urandom_range(1, 1000));
            endcase
            write_dit(dit);
            if (p == 2)
            begin
                hold_req = 1'b1;
            end
            if (p == N_PHASES - 1)
            begin
                no_idle = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: ch = 8'("A" + $urandom_range(0, 25));
                    5, 6:          ch = 8'("0" + $urandom_range(0, 9));
                    7, 8:          ch = 8'($urandom_range(0, 255));
                    default:
                    begin
                        case ($urandom_range(0, 5))
                            0: ch = "@";
                            1: ch = "[";
                            2: ch = "/";
                            3: ch = ":";
                            4: ch = "a";
                            default: ch = "z";
                        endcase
                    end
                endcase
                send_char(ch, $urandom_range(0, 3) == 0);
            end
            drain_segments();
        end

        if (err_count == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule : tb_morse_code_keyer_top
